/* hdl/priority_scheduler_with_aging_defines.svh */
// Assertion macros used by the priority scheduler sequencer (psa_ctrl).
// Plain text macros only; no dependencies.
`ifndef PRIORITY_SCHEDULER_WITH_AGING_DEFINES_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_DEFINES_SVH

// same-cycle implication
`define PSA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/psa_pkg.sv */
// Types and codes for the priority scheduler with aging.
// No dependencies.
package psa_pkg;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] slot;
        logic [2:0] priority_req;
        logic       exempt;
    } in_item_t;

    typedef struct packed {
        logic [3:0] running_slot;
        logic       running_valid;
        logic       switched;
        logic [2:0] quantum_left;
        logic [1:0] status;
    } out_item_t;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_ADMIT   = 3'd1;
    localparam logic [2:0] CMD_YIELD   = 3'd2;
    localparam logic [2:0] CMD_BLOCK   = 3'd3;
    localparam logic [2:0] CMD_UNBLOCK = 3'd4;
    localparam logic [2:0] CMD_EXIT    = 3'd5;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BAD    = 2'd1;
    localparam logic [1:0] STAT_NOTBLK = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    localparam logic [2:0] TS_FREE    = 3'd0;
    localparam logic [2:0] TS_READY   = 3'd1;
    localparam logic [2:0] TS_RUNNING = 3'd2;
    localparam logic [2:0] TS_BLOCKED = 3'd3;
    localparam logic [2:0] TS_EXITED  = 3'd4;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LATCH    = 4'd1;
    localparam logic [3:0] OP_EXEC     = 4'd2;
    localparam logic [3:0] OP_SW_HEAD  = 4'd3;
    localparam logic [3:0] OP_AGE_LOAD = 4'd4;
    localparam logic [3:0] OP_AGE_STEP = 4'd5;
    localparam logic [3:0] OP_AGE_EVAL = 4'd6;
    localparam logic [3:0] OP_BOOST    = 4'd7;
    localparam logic [3:0] OP_AGE_PUSH = 4'd8;
    localparam logic [3:0] OP_SEL_STEP = 4'd9;
    localparam logic [3:0] OP_SEL_EVAL = 4'd10;

    typedef struct packed {
        logic [3:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic go_switch;
        logic sw_nocur;
        logic sw_spend;
        logic n_zero;
        logic lv_last;
        logic exempt;
        logic boost_done;
        logic sel_nz;
        logic lv_zero;
        logic sel_hit;
    } dp_stat_t;

endpackage

/* hdl/psa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 80
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule

/* hdl/psa_ctrl.sv */
// Sequencer of the scheduler: steps the datapath through one command.
// Depends on psa_pkg and the assertion macro header.
`include "priority_scheduler_with_aging_defines.svh"
module psa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               out_free,
    output logic               out_load,
    input  psa_pkg::dp_stat_t  stat,
    output psa_pkg::dp_cmd_t   cmd
);
    import psa_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_SW       = 4'd2;
    localparam logic [3:0] ST_AGE_LVL  = 4'd3;
    localparam logic [3:0] ST_AGE_CHK  = 4'd4;
    localparam logic [3:0] ST_AGE_EVAL = 4'd5;
    localparam logic [3:0] ST_BOOST    = 4'd6;
    localparam logic [3:0] ST_AGE_PUSH = 4'd7;
    localparam logic [3:0] ST_SEL_CHK  = 4'd8;
    localparam logic [3:0] ST_SEL_EVAL = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LATCH;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.op     = OP_EXEC;
                state_next = stat.go_switch ? ST_SW : ST_DONE;
            end
            ST_SW: begin
                cmd.op = OP_SW_HEAD;
                priority if (stat.sw_nocur) state_next = ST_SEL_CHK;
                else if (stat.sw_spend) state_next = ST_DONE;
                else state_next = ST_AGE_LVL;
            end
            ST_AGE_LVL: begin
                cmd.op     = OP_AGE_LOAD;
                state_next = ST_AGE_CHK;
            end
            ST_AGE_CHK: begin
                cmd.op = OP_AGE_STEP;
                priority if (!stat.n_zero) state_next = ST_AGE_EVAL;
                else if (stat.lv_last) state_next = ST_SEL_CHK;
                else state_next = ST_AGE_LVL;
            end
            ST_AGE_EVAL: begin
                cmd.op     = OP_AGE_EVAL;
                state_next = stat.exempt ? ST_AGE_CHK : ST_BOOST;
            end
            ST_BOOST: begin
                cmd.op = OP_BOOST;
                if (stat.boost_done) state_next = ST_AGE_PUSH;
            end
            ST_AGE_PUSH: begin
                cmd.op     = OP_AGE_PUSH;
                state_next = ST_AGE_CHK;
            end
            ST_SEL_CHK: begin
                cmd.op = OP_SEL_STEP;
                priority if (stat.sel_nz) state_next = ST_SEL_EVAL;
                else if (stat.lv_zero) state_next = ST_DONE;
                else state_next = ST_SEL_CHK;
            end
            ST_SEL_EVAL: begin
                cmd.op     = OP_SEL_EVAL;
                state_next = stat.sel_hit ? ST_DONE : ST_SEL_CHK;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `PSA_ASSERT_NXT(a_accept_decode, aclk, aresetn, s_valid && s_ready,
        state_reg == ST_DECODE, "accepted transfer not decoded")
    `PSA_ASSERT_IMP(a_age_rd_lat, aclk, aresetn, state_reg == ST_AGE_EVAL,
        $past(state_reg) == ST_AGE_CHK, "aging eval without fifo read")
    `PSA_ASSERT_IMP(a_sel_rd_lat, aclk, aresetn, state_reg == ST_SEL_EVAL,
        $past(state_reg) == ST_SEL_CHK, "select eval without fifo read")
endmodule

/* hdl/psa_dpath.sv */
// Datapath of the scheduler: slot records, level FIFOs, aging and selection.
// Depends on psa_pkg and psa_ram.
module psa_dpath #(
    parameter int NUM_LEVELS = 5,
    parameter int NUM_SLOTS  = 16,
    parameter int WAIT_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  psa_pkg::dp_cmd_t     cmd,
    output psa_pkg::dp_stat_t    stat,
    input  psa_pkg::in_item_t    s_item,
    input  logic [15:0]          wait_thresh,
    input  logic [2:0]           max_boost,
    output psa_pkg::out_item_t   result
);
    import psa_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int LV_W   = $clog2(NUM_LEVELS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int DEPTH  = NUM_LEVELS * NUM_SLOTS;
    localparam int AD_W   = $clog2(DEPTH);
    localparam int AW     = ((WAIT_BITS > 16) ? WAIT_BITS : 16) + 4;

    function automatic logic [LV_W-1:0] lvl_of(input logic [2:0] p);
        if (p == 3'd0) return '0;
        else if (p > 3'(NUM_LEVELS)) return LV_W'(NUM_LEVELS - 1);
        else return LV_W'(p - 3'd1);
    endfunction

    function automatic logic [AD_W-1:0] fifo_addr(input logic [LV_W-1:0] lv,
                                                  input logic [SLOT_W:0] pos);
        logic [SLOT_W:0] wp;
        wp = (pos < (SLOT_W+1)'(NUM_SLOTS)) ? pos : pos - (SLOT_W+1)'(NUM_SLOTS);
        return AD_W'(AD_W'(lv) * AD_W'(NUM_SLOTS)) + AD_W'(wp);
    endfunction

    in_item_t            in_reg, in_next;
    logic [1:0]          status_reg, status_next;
    logic                full_reg, full_next;
    logic                sw_reg, sw_next;
    logic                yield_reg, yield_next;
    logic [SLOT_W-1:0]   cur_reg, cur_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [2:0]          quant_reg, quant_next;
    logic [LV_W-1:0]     lv_reg, lv_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [SLOT_W-1:0]   s_reg, s_next;
    logic [AW-1:0]       acc_reg, acc_next;
    logic [2:0]          boost_reg, boost_next;

    logic [2:0]           tst_reg  [NUM_SLOTS], tst_next  [NUM_SLOTS];
    logic [2:0]           pri_reg  [NUM_SLOTS], pri_next  [NUM_SLOTS];
    logic [2:0]           base_reg [NUM_SLOTS], base_next [NUM_SLOTS];
    logic [WAIT_BITS-1:0] wait_reg [NUM_SLOTS], wait_next [NUM_SLOTS];
    logic                 exm_reg  [NUM_SLOTS], exm_next  [NUM_SLOTS];
    logic [SLOT_W-1:0]    head_reg [NUM_LEVELS], head_next [NUM_LEVELS];
    logic [CNT_W-1:0]     cnt_reg  [NUM_LEVELS], cnt_next  [NUM_LEVELS];

    logic                wr_en, rd_en;
    logic [AD_W-1:0]     wr_addr, rd_addr;
    logic [SLOT_W-1:0]   wr_data, rd_data;

    logic                push_en, pop_en;
    logic [LV_W-1:0]     push_lv;
    logic [SLOT_W-1:0]   push_data;

    logic [SLOT_W-1:0]   idx;
    logic                slot_ok;
    logic [15:0]         thr_eff;
    logic [3:0]          np_sum;
    logic [2:0]          np;
    logic [LV_W-1:0]     tl, alv;

    psa_ram #(.WIDTH(SLOT_W), .DEPTH(DEPTH)) u_fifo_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx     = SLOT_W'(in_reg.slot);
    assign slot_ok = 7'(in_reg.slot) < 7'(NUM_SLOTS);
    assign thr_eff = (wait_thresh == 16'd0) ? 16'd1 : wait_thresh;

    always_comb begin
        stat.go_switch = (in_reg.command == CMD_TICK) || (in_reg.command == CMD_YIELD)
            || ((in_reg.command == CMD_BLOCK) && slot_ok && (tst_reg[idx] != TS_FREE)
                && cur_valid_reg && (cur_reg == idx));
        stat.sw_nocur   = !cur_valid_reg;
        stat.sw_spend   = cur_valid_reg && (tst_reg[cur_reg] == TS_RUNNING)
                          && (quant_reg != 3'd0) && !yield_reg;
        stat.n_zero     = (n_reg == '0);
        stat.lv_last    = (lv_reg == LV_W'(NUM_LEVELS - 1));
        stat.exempt     = exm_reg[rd_data];
        stat.boost_done = !((acc_reg <= AW'(wait_reg[s_reg])) && (boost_reg < max_boost));
        stat.sel_nz     = (cnt_reg[lv_reg] != '0);
        stat.lv_zero    = (lv_reg == '0);
        stat.sel_hit    = (tst_reg[rd_data] == TS_READY);
    end

    assign np_sum = 4'(base_reg[s_reg]) + 4'(boost_reg);
    always_comb begin
        np = pri_reg[s_reg];
        if ((AW'(thr_eff) <= AW'(wait_reg[s_reg])) && (pri_reg[s_reg] < 3'(NUM_LEVELS))) begin
            np = (np_sum > 4'(NUM_LEVELS)) ? 3'(NUM_LEVELS) : np_sum[2:0];
        end
    end
    assign tl  = lvl_of(np);
    assign alv = LV_W'(in_reg.priority_req - 3'd1);

    always_comb begin
        in_next        = in_reg;
        status_next    = status_reg;
        full_next      = full_reg;
        sw_next        = sw_reg;
        yield_next     = yield_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        quant_next     = quant_reg;
        lv_next        = lv_reg;
        n_next         = n_reg;
        s_next         = s_reg;
        acc_next       = acc_reg;
        boost_next     = boost_reg;
        tst_next       = tst_reg;
        pri_next       = pri_reg;
        base_next      = base_reg;
        wait_next      = wait_reg;
        exm_next       = exm_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        push_en        = 1'b0;
        push_lv        = '0;
        push_data      = '0;
        pop_en         = 1'b0;

        unique case (cmd.op)
            OP_LATCH: begin
                in_next     = s_item;
                status_next = STAT_OK;
                full_next   = 1'b0;
                sw_next     = 1'b0;
            end
            OP_EXEC: begin
                unique case (in_reg.command)
                    CMD_YIELD: yield_next = 1'b1;
                    CMD_ADMIT: begin
                        if (!slot_ok || (tst_reg[idx] != TS_FREE)
                            || (in_reg.priority_req == 3'd0)
                            || (in_reg.priority_req > 3'(NUM_LEVELS))) begin
                            status_next = STAT_BAD;
                        end else if (cnt_reg[alv] >= CNT_W'(NUM_SLOTS)) begin
                            status_next = STAT_FULL;
                        end else begin
                            push_en         = 1'b1;
                            push_lv         = alv;
                            push_data       = idx;
                            tst_next[idx]   = TS_READY;
                            pri_next[idx]   = in_reg.priority_req;
                            base_next[idx]  = in_reg.priority_req;
                            wait_next[idx]  = '0;
                            exm_next[idx]   = in_reg.exempt;
                        end
                    end
                    CMD_BLOCK: begin
                        if (!slot_ok || (tst_reg[idx] == TS_FREE)) begin
                            status_next = STAT_BAD;
                        end else begin
                            tst_next[idx] = TS_BLOCKED;
                            if (cur_valid_reg && (cur_reg == idx)) yield_next = 1'b1;
                        end
                    end
                    CMD_UNBLOCK: begin
                        if (!slot_ok) begin
                            status_next = STAT_BAD;
                        end else if (tst_reg[idx] != TS_BLOCKED) begin
                            status_next = STAT_NOTBLK;
                        end else if (cnt_reg[lvl_of(pri_reg[idx])] >= CNT_W'(NUM_SLOTS)) begin
                            status_next = STAT_FULL;
                        end else begin
                            push_en       = 1'b1;
                            push_lv       = lvl_of(pri_reg[idx]);
                            push_data     = idx;
                            tst_next[idx] = TS_READY;
                        end
                    end
                    CMD_EXIT: begin
                        if (!slot_ok || (tst_reg[idx] == TS_FREE)) status_next = STAT_BAD;
                        else tst_next[idx] = TS_EXITED;
                    end
                    default: ;
                endcase
            end
            OP_SW_HEAD: begin
                if (!cur_valid_reg) begin
                    lv_next = LV_W'(NUM_LEVELS - 1);
                end else if (tst_reg[cur_reg] == TS_RUNNING) begin
                    if ((quant_reg != 3'd0) && !yield_reg) begin
                        quant_next = quant_reg - 3'd1;
                    end else begin
                        tst_next[cur_reg] = TS_READY;
                        pri_next[cur_reg] = base_reg[cur_reg];
                        if (cnt_reg[lvl_of(base_reg[cur_reg])] < CNT_W'(NUM_SLOTS)) begin
                            push_en   = 1'b1;
                            push_lv   = lvl_of(base_reg[cur_reg]);
                            push_data = cur_reg;
                        end else begin
                            full_next = 1'b1;
                        end
                        lv_next = '0;
                    end
                end else begin
                    quant_next = 3'd0;
                    lv_next    = '0;
                end
            end
            OP_AGE_LOAD: n_next = cnt_reg[lv_reg];
            OP_AGE_STEP: begin
                if (n_reg == '0) begin
                    if (lv_reg != LV_W'(NUM_LEVELS - 1)) lv_next = lv_reg + 1'b1;
                end else begin
                    pop_en = 1'b1;
                    n_next = n_reg - 1'b1;
                end
            end
            OP_AGE_EVAL: begin
                s_next = rd_data;
                if (exm_reg[rd_data]) begin
                    push_en   = 1'b1;
                    push_lv   = lv_reg;
                    push_data = rd_data;
                end else begin
                    if (wait_reg[rd_data] != '1) wait_next[rd_data] = wait_reg[rd_data] + 1'b1;
                    acc_next   = AW'(thr_eff);
                    boost_next = 3'd0;
                end
            end
            OP_BOOST: begin
                if (!stat.boost_done) begin
                    boost_next = boost_reg + 3'd1;
                    acc_next   = acc_reg + AW'(thr_eff);
                end
            end
            OP_AGE_PUSH: begin
                push_en   = 1'b1;
                push_data = s_reg;
                if (cnt_reg[tl] < CNT_W'(NUM_SLOTS)) begin
                    push_lv         = tl;
                    pri_next[s_reg] = np;
                end else begin
                    push_lv   = lv_reg;
                    full_next = 1'b1;
                end
            end
            OP_SEL_STEP: begin
                if (cnt_reg[lv_reg] != '0) pop_en = 1'b1;
                else if (lv_reg == '0) cur_valid_next = 1'b0;
                else lv_next = lv_reg - 1'b1;
            end
            OP_SEL_EVAL: begin
                if (tst_reg[rd_data] == TS_READY) begin
                    yield_next         = 1'b0;
                    quant_next         = (pri_reg[rd_data] != 3'd0) ? pri_reg[rd_data] - 3'd1
                                                                    : 3'd0;
                    tst_next[rd_data]  = TS_RUNNING;
                    wait_next[rd_data] = '0;
                    cur_next           = rd_data;
                    cur_valid_next     = 1'b1;
                    sw_next            = 1'b1;
                end
            end
            default: ;
        endcase

        wr_en   = push_en;
        wr_data = push_data;
        wr_addr = fifo_addr(push_lv,
                            (SLOT_W+1)'(head_reg[push_lv]) + (SLOT_W+1)'(cnt_reg[push_lv]));
        if (push_en) cnt_next[push_lv] = cnt_reg[push_lv] + 1'b1;

        rd_en   = pop_en;
        rd_addr = fifo_addr(lv_reg, (SLOT_W+1)'(head_reg[lv_reg]));
        if (pop_en) begin
            head_next[lv_reg] = (head_reg[lv_reg] == SLOT_W'(NUM_SLOTS - 1)) ? '0
                                : head_reg[lv_reg] + 1'b1;
            cnt_next[lv_reg]  = cnt_reg[lv_reg] - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg    <= in_next;
        lv_reg    <= lv_next;
        n_reg     <= n_next;
        s_reg     <= s_next;
        acc_reg   <= acc_next;
        boost_reg <= boost_next;
        if (!aresetn) begin
            status_reg    <= STAT_OK;
            full_reg      <= 1'b0;
            sw_reg        <= 1'b0;
            yield_reg     <= 1'b0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            quant_reg     <= 3'd0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                tst_reg[i]  <= TS_FREE;
                pri_reg[i]  <= 3'd0;
                base_reg[i] <= 3'd0;
                wait_reg[i] <= '0;
                exm_reg[i]  <= 1'b0;
            end
            for (int l = 0; l < NUM_LEVELS; l++) begin
                head_reg[l] <= '0;
                cnt_reg[l]  <= '0;
            end
        end else begin
            status_reg    <= status_next;
            full_reg      <= full_next;
            sw_reg        <= sw_next;
            yield_reg     <= yield_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            quant_reg     <= quant_next;
            tst_reg       <= tst_next;
            pri_reg       <= pri_next;
            base_reg      <= base_next;
            wait_reg      <= wait_next;
            exm_reg       <= exm_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_comb begin
        result.running_slot  = cur_valid_reg ? 4'(cur_reg) : 4'd0;
        result.running_valid = cur_valid_reg;
        result.switched      = sw_reg;
        result.quantum_left  = cur_valid_reg ? quant_reg : 3'd0;
        result.status        = full_reg ? STAT_FULL : status_reg;
    end
endmodule

/* hdl/priority_scheduler_with_aging.sv */
// Top level of the multilevel priority scheduler with aging.
// Depends on psa_pkg, psa_ctrl, psa_dpath, psa_ram.
//
//   channel  | ports               | moves
//   ---------+---------------------+-------------------------------
//   command  | s_valid/s_ready     | one in_item_t per transfer
//   result   | m_valid/m_ready     | one out_item_t per command
//   config   | APB psel..pready    | wait threshold @0, max_boost @4
//
// Simple commands pass only through the decode and done states. A switch
// takes each queued entry through check, evaluate, boost and push for aging,
// with up to 7 boost steps each, and checks then evaluates each popped entry.
// Reset is synchronous; no clearing pass. The next command is taken while a
// result waits in the output register; a stalled output holds the sequencer.
module priority_scheduler_with_aging #(
    parameter int NUM_LEVELS = 5,
    parameter int NUM_SLOTS  = 16,
    parameter int WAIT_BITS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  psa_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output psa_pkg::out_item_t  m_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import psa_pkg::*;

    logic [15:0] thr_reg, thr_next;
    logic [2:0]  maxb_reg, maxb_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_item_reg, m_item_next;
    logic        out_free, out_load;
    dp_cmd_t     dcmd;
    dp_stat_t    dstat;
    out_item_t   result;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {29'd0, maxb_reg} : {16'd0, thr_reg};

    always_comb begin
        thr_next  = thr_reg;
        maxb_next = maxb_reg;
        if (psel && penable && pwrite) begin
            if (paddr[2]) maxb_next = pwdata[2:0];
            else thr_next = pwdata[15:0];
        end
    end

    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign m_item_next  = out_load ? result : m_item_reg;
    assign m_valid      = m_valid_reg;
    assign m_item       = m_item_reg;

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
        if (!aresetn) begin
            thr_reg     <= 16'd10;
            maxb_reg    <= 3'd2;
            m_valid_reg <= 1'b0;
        end else begin
            thr_reg     <= thr_next;
            maxb_reg    <= maxb_next;
            m_valid_reg <= m_valid_next;
        end
    end

    psa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (dstat),
        .cmd      (dcmd)
    );

    psa_dpath #(
        .NUM_LEVELS (NUM_LEVELS),
        .NUM_SLOTS  (NUM_SLOTS),
        .WAIT_BITS  (WAIT_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (dcmd),
        .stat        (dstat),
        .s_item      (s_item),
        .wait_thresh (thr_reg),
        .max_boost   (maxb_reg),
        .result      (result)
    );
endmodule

/* tb/priority_scheduler_with_aging_tb.sv */
// Self-checking testbench for priority_scheduler_with_aging: drives scheduler commands,
// predicts each result with a behavioral scheduler model and compares every field.
// Depends on psa_pkg and the priority_scheduler_with_aging RTL.
module priority_scheduler_with_aging_tb;
    import psa_pkg::*;

    localparam int LEVELS = 5;
    localparam int SLOTS  = 16;
    localparam int WMAX   = 65535;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 0;
    out_item_t m_item;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    priority_scheduler_with_aging uut (.*);

    initial forever #5 aclk = ~aclk;

    // scheduler state mirror
    logic [2:0]  ts_state [SLOTS];
    logic [2:0]  ts_prio  [SLOTS];
    logic [2:0]  ts_base  [SLOTS];
    int unsigned ts_wait  [SLOTS];
    logic        ts_exempt[SLOTS];
    int unsigned lvq[LEVELS][$];
    int unsigned cur_slot;
    bit          cur_valid;
    int unsigned quantum;
    bit          yield_pend;
    int unsigned thr_reg;
    int unsigned boost_reg;

    in_item_t  cmd_q[$];
    out_item_t sched_expect_q[$];
    int  errors = 0;
    int  snd_idle = 0, rcv_idle = 0;
    bit  hold_off = 0;

    function automatic int unsigned lvl_of(int unsigned p);
        if (p < 1) return 0;
        if (p > LEVELS) return LEVELS - 1;
        return p - 1;
    endfunction

    function automatic bit lv_push(int unsigned lv, int unsigned s);
        if (lvq[lv].size() >= SLOTS) return 0;
        lvq[lv].push_back(s);
        return 1;
    endfunction

    task automatic age_all(inout bit full);
        int unsigned n, s, np, bst, thr;
        thr = (thr_reg == 0) ? 1 : thr_reg;
        for (int lv = 0; lv < LEVELS; lv++) begin
            n = lvq[lv].size();
            for (int i = 0; i < n; i++) begin
                s = lvq[lv].pop_front();
                if (ts_exempt[s]) begin
                    void'(lv_push(lv, s));
                    continue;
                end
                if (ts_wait[s] < WMAX) ts_wait[s]++;
                np = ts_prio[s];
                if (ts_wait[s] >= thr && np < LEVELS) begin
                    bst = ts_wait[s] / thr;
                    if (bst > boost_reg) bst = boost_reg;
                    np = ts_base[s] + bst;
                    if (np > LEVELS) np = LEVELS;
                end
                if (lv_push(lvl_of(np), s)) ts_prio[s] = 3'(np);
                else begin
                    full = 1;
                    void'(lv_push(lv, s));
                end
            end
        end
    endtask

    task automatic sched_switch(inout bit full, output bit sw);
        int unsigned s;
        sw = 0;
        if (cur_valid) begin
            if (ts_state[cur_slot] == TS_RUNNING) begin
                if (quantum > 0 && !yield_pend) begin
                    quantum--;
                    return;
                end
                ts_state[cur_slot] = TS_READY;
                ts_prio[cur_slot] = ts_base[cur_slot];
                if (!lv_push(lvl_of(ts_base[cur_slot]), cur_slot)) full = 1;
            end else quantum = 0;
            age_all(full);
        end
        for (int lv = LEVELS - 1; lv >= 0; lv--) begin
            while (lvq[lv].size() > 0) begin
                s = lvq[lv].pop_front();
                if (ts_state[s] != TS_READY) continue;
                yield_pend = 0;
                quantum = (ts_prio[s] >= 1 ? ts_prio[s] - 1 : 0) & 7;
                ts_state[s] = TS_RUNNING;
                ts_wait[s] = 0;
                cur_slot = s;
                cur_valid = 1;
                sw = 1;
                return;
            end
        end
        cur_valid = 0;
    endtask

    task automatic sched_predict(input in_item_t it);
        bit full, sw;
        logic [1:0] st;
        out_item_t r;
        int unsigned s, p;
        full = 0; sw = 0; st = STAT_OK;
        s = it.slot; p = it.priority_req;
        case (it.command)
            CMD_TICK: sched_switch(full, sw);
            CMD_YIELD: begin
                yield_pend = 1;
                sched_switch(full, sw);
            end
            CMD_ADMIT: begin
                if (ts_state[s] != TS_FREE || p < 1 || p > LEVELS) st = STAT_BAD;
                else if (!lv_push(p - 1, s)) st = STAT_FULL;
                else begin
                    ts_state[s] = TS_READY;
                    ts_prio[s] = 3'(p);
                    ts_base[s] = 3'(p);
                    ts_wait[s] = 0;
                    ts_exempt[s] = it.exempt;
                end
            end
            CMD_BLOCK: begin
                if (ts_state[s] == TS_FREE) st = STAT_BAD;
                else begin
                    ts_state[s] = TS_BLOCKED;
                    if (cur_valid && cur_slot == s) begin
                        yield_pend = 1;
                        sched_switch(full, sw);
                    end
                end
            end
            CMD_UNBLOCK: begin
                if (ts_state[s] != TS_BLOCKED) st = STAT_NOTBLK;
                else if (!lv_push(lvl_of(ts_prio[s]), s)) st = STAT_FULL;
                else ts_state[s] = TS_READY;
            end
            CMD_EXIT: begin
                if (ts_state[s] == TS_FREE) st = STAT_BAD;
                else ts_state[s] = TS_EXITED;
            end
            default: ;
        endcase
        if (full) st = STAT_FULL;
        r.running_slot  = cur_valid ? cur_slot[3:0] : 4'd0;
        r.running_valid = cur_valid;
        r.switched      = sw;
        r.quantum_left  = cur_valid ? quantum[2:0] : 3'd0;
        r.status        = st;
        sched_expect_q.push_back(r);
    endtask

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sched_predict(s_item);
            if (!(s_valid && !s_ready)) begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
                    s_item <= cmd_q.pop_front();
                    s_valid <= 1;
                end else s_valid <= 0;
            end
            m_ready <= !hold_off && ($urandom_range(99) >= rcv_idle);
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (sched_expect_q.size() == 0) report("result with nothing expected");
            else begin
                e = sched_expect_q.pop_front();
                if (m_item.running_slot !== e.running_slot)
                    report($sformatf("running_slot %0d exp %0d", m_item.running_slot,
                        e.running_slot));
                if (m_item.running_valid !== e.running_valid)
                    report($sformatf("running_valid %0b exp %0b", m_item.running_valid,
                        e.running_valid));
                if (m_item.switched !== e.switched)
                    report($sformatf("switched %0b exp %0b", m_item.switched, e.switched));
                if (m_item.quantum_left !== e.quantum_left)
                    report($sformatf("quantum_left %0d exp %0d", m_item.quantum_left,
                        e.quantum_left));
                if (m_item.status !== e.status)
                    report($sformatf("status %0d exp %0d", m_item.status, e.status));
            end
        end
    end

    function automatic in_item_t mk(logic [2:0] c, int s, int p, int x);
        in_item_t it;
        it.command = c; it.slot = 4'(s); it.priority_req = 3'(p); it.exempt = 1'(x);
        return it;
    endfunction

    function automatic in_item_t rand_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 45) return mk(CMD_TICK, $urandom_range(15), $urandom_range(7),
            $urandom_range(1));
        if (r < 55) return mk(CMD_YIELD, $urandom_range(15), $urandom_range(7),
            $urandom_range(1));
        if (r < 70) return mk(CMD_ADMIT, $urandom_range(15),
            ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(LEVELS, 1),
            $urandom_range(1));
        if (r < 80) return mk(CMD_BLOCK, $urandom_range(15), $urandom_range(7),
            $urandom_range(1));
        if (r < 92) return mk(CMD_UNBLOCK, $urandom_range(15), $urandom_range(7),
            $urandom_range(1));
        if (r < 98) return mk(CMD_EXIT, $urandom_range(15), $urandom_range(7),
            $urandom_range(1));
        return mk(3'($urandom_range(7, 6)), $urandom_range(15), $urandom_range(7),
            $urandom_range(1));
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == 3'd0) thr_reg = data[15:0];
        else boost_reg = data[2:0];
        @(posedge aclk);
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || s_valid || sched_expect_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic run_phase(int n, int sidle, int ridle);
        snd_idle = sidle; rcv_idle = ridle;
        repeat (n) cmd_q.push_back(rand_cmd());
        drain();
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            ts_state[i] = TS_FREE; ts_prio[i] = 0; ts_base[i] = 0;
            ts_wait[i] = 0; ts_exempt[i] = 0;
        end
        cur_slot = 0; cur_valid = 0; quantum = 0; yield_pend = 0;
        thr_reg = 10; boost_reg = 2;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed
        cmd_q.push_back(mk(CMD_TICK, 0, 0, 0));
        cmd_q.push_back(mk(CMD_ADMIT, 0, 0, 0));
        cmd_q.push_back(mk(CMD_ADMIT, 0, 6, 0));
        cmd_q.push_back(mk(CMD_ADMIT, 0, 1, 0));
        cmd_q.push_back(mk(CMD_ADMIT, 0, 3, 0));
        cmd_q.push_back(mk(CMD_ADMIT, 15, 5, 1));
        cmd_q.push_back(mk(CMD_ADMIT, 7, 7, 1));
        cmd_q.push_back(mk(CMD_ADMIT, 7, 3, 0));
        cmd_q.push_back(mk(CMD_BLOCK, 9, 0, 0));
        cmd_q.push_back(mk(CMD_EXIT, 9, 0, 0));
        cmd_q.push_back(mk(CMD_UNBLOCK, 0, 0, 0));
        cmd_q.push_back(mk(CMD_TICK, 0, 0, 0));
        cmd_q.push_back(mk(CMD_TICK, 0, 0, 0));
        cmd_q.push_back(mk(CMD_BLOCK, 15, 0, 0));
        cmd_q.push_back(mk(CMD_UNBLOCK, 15, 0, 0));
        cmd_q.push_back(mk(CMD_YIELD, 0, 0, 0));
        cmd_q.push_back(mk(CMD_EXIT, 7, 0, 0));
        cmd_q.push_back(mk(CMD_ADMIT, 7, 2, 0));
        cmd_q.push_back(mk(3'd6, 15, 7, 1));
        cmd_q.push_back(mk(3'd7, 0, 0, 0));
        repeat (4) cmd_q.push_back(mk(CMD_TICK, 0, 0, 0));
        drain();

        run_phase(150, 0, 0);
        // receiver holds off while sender keeps offering
        hold_off = 1;
        repeat (40) cmd_q.push_back(rand_cmd());
        repeat (400) @(posedge aclk);
        hold_off = 0;
        drain();
        apb_write(3'd0, 32'd1);
        apb_write(3'd4, 32'd7);
        run_phase(150, 82, 0);
        apb_write(3'd0, 32'd65535);
        apb_write(3'd4, 32'd0);
        run_phase(150, 0, 82);
        apb_write(3'd0, 32'd3);
        apb_write(3'd4, 32'd3);
        run_phase(200, 15, 15);
        apb_write(3'd0, 32'd0);
        apb_write(3'd4, 32'd5);
        run_phase(220, 0, 0);

        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #100000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
